// File: hw/rtl/assert_macros.svh
// Assertion helpers included by the order engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/tsoe_pkg.sv
package tsoe_pkg;

  // Field widths
  localparam int unsigned PRICE_W    = 24;
  localparam int unsigned INST_W     = 4;
  localparam int unsigned PCT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PCT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PCT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;

  // Configuration reset values
  localparam logic [PRICE_W-1:0] LOW_LIMIT_RST  = 24'd10500;
  localparam logic [PRICE_W-1:0] HIGH_LIMIT_RST = 24'd19500;
  localparam logic [PCT_W-1:0]   LOW_PCT_RST    = 8'd70;
  localparam logic [PCT_W-1:0]   HIGH_PCT_RST   = 8'd130;
  localparam logic [PCT_W-1:0]   OFFSET_RST     = 8'd1;

  // Test constants
  localparam int unsigned        DEV_MIN_COUNT = 5;
  localparam int unsigned        MOM_MIN_COUNT = 3;
  localparam logic [PCT_W-1:0]   PCT_SCALE     = 8'd100;
  localparam logic [PRICE_W-1:0] PRICE_MAX     = 24'hFF_FFFF;

  typedef struct packed {
    logic [INST_W-1:0]  inst_id;
    logic [PRICE_W-1:0] price;
  } tick_t;

  typedef struct packed {
    logic               order_valid;
    logic               is_buy;
    logic [PRICE_W-1:0] order_price;
    logic [INST_W-1:0]  order_instrument;
    logic               threshold_hit;
    logic               deviation_hit;
    logic               momentum_hit;
  } order_t;

endpackage

// File: hw/rtl/tsoe_mul.sv
module tsoe_mul #(
  parameter int unsigned A_W = 29,
  parameter int unsigned B_W = 8
) (
  input  logic             clk_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;

  // Register the product of the selected operands
  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/tick_signal_order_engine_core.sv
// Tick signal order engine.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one tick: an
// instrument id and a price in hundredths. Output channel (out_valid_o /
// out_stall_i / out_data_o) gives exactly one result per tick: order flag,
// side, saturated order price, echoed instrument and the three test hits.
// Thresholds, deviation percentages and order offset are set through the
// write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Each tick walks a nine-state sequencer: three reads of the price window
// memory (evicted, previous and second previous price, one read port), then
// four passes through one shared registered multiplier (price*count,
// times 100, sum*low pct, sum*high pct), then result assembly. A new tick
// is taken only once the sequencer is back in idle. A tick for an
// instrument out of range goes straight to result assembly. A result waits
// in the output register while the receiver stalls; the next tick is still
// taken and processed, and holds in the last state until the output
// register frees. Reset clears window sums, fill counts and write slots of
// every instrument and loads the default configuration; the window memory
// itself is not cleared.
`include "assert_macros.svh"

module tick_signal_order_engine_core #(
  parameter int unsigned WINDOW          = 10,
  parameter int unsigned NUM_INSTRUMENTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tsoe_pkg::tick_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tsoe_pkg::order_t                    out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tsoe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsoe_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import tsoe_pkg::*;

  localparam int unsigned NI_EFF    = (NUM_INSTRUMENTS > 16) ? 16 : NUM_INSTRUMENTS;
  localparam int unsigned IDX_W     = (NI_EFF > 1) ? $clog2(NI_EFF) : 1;
  localparam int unsigned CNT_W     = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W    = $clog2(WINDOW);
  localparam int unsigned SUM_W     = PRICE_W + CNT_W;
  localparam int unsigned PROD_W    = SUM_W + PCT_W;
  localparam int unsigned MEM_DEPTH = NI_EFF * WINDOW;
  localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD_EV = 9'b000000010,
    S_RD_P1 = 9'b000000100,
    S_RD_P2 = 9'b000001000,
    S_MUL0  = 9'b000010000,
    S_MUL1  = 9'b000100000,
    S_MUL2  = 9'b001000000,
    S_MUL3  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [PRICE_W-1:0] low_limit_q, high_limit_q;
  logic [PCT_W-1:0]   low_pct_q, high_pct_q, offset_q;

  // Per-instrument window bookkeeping
  logic [SUM_W-1:0]  sum_arr_q  [NI_EFF];
  logic [CNT_W-1:0]  cnt_arr_q  [NI_EFF];
  logic [SLOT_W-1:0] slot_arr_q [NI_EFF];

  // Price window memory
  logic [PRICE_W-1:0] mem_q [MEM_DEPTH];
  logic [PRICE_W-1:0] rd_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  base_addr;
  logic               mem_we;

  // Tick context
  logic [INST_W-1:0]  inst_q;
  logic [PRICE_W-1:0] price_q;
  logic               vld_q;
  logic [PRICE_W-1:0] ev_q, p1_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  lhs_q;
  logic               below_q, dev_lo_q, mom_q;

  // Shared multiplier
  logic [SUM_W-1:0]  mul_a;
  logic [PCT_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  // Output register
  logic   out_valid_q;
  order_t out_q, result;

  logic [IDX_W-1:0]  idx;
  logic [SLOT_W-1:0] slot_cur, slot_m1, slot_m2, slot_nxt;
  logic [CNT_W-1:0]  cnt_cur;
  logic [SUM_W-1:0]  sum_cur, sum_new;
  logic              full;
  logic              in_acc, out_load;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign idx      = inst_q[IDX_W-1:0];
  assign slot_cur = slot_arr_q[idx];
  assign cnt_cur  = cnt_arr_q[idx];
  assign sum_cur  = sum_arr_q[idx];
  assign full     = (32'(cnt_cur) == WINDOW);

  // Walk the ring slots around the write position
  assign slot_nxt = (32'(slot_cur) == WINDOW - 1) ? '0 : slot_cur + 1'b1;
  assign slot_m1  = (slot_cur == '0) ? SLOT_W'(WINDOW - 1) : slot_cur - 1'b1;
  assign slot_m2  = (32'(slot_cur) < 2) ? SLOT_W'(32'(slot_cur) + WINDOW - 2)
                                        : SLOT_W'(32'(slot_cur) - 2);

  assign sum_new = full ? (sum_cur - SUM_W'(ev_q) + SUM_W'(price_q))
                        : (sum_cur + SUM_W'(price_q));

  // Select the memory read address for the current step
  assign base_addr = ADDR_W'(idx) * ADDR_W'(WINDOW);
  always_comb begin
    case (state_q)
      S_RD_P1: rd_addr = base_addr + ADDR_W'(slot_m1);
      S_RD_P2: rd_addr = base_addr + ADDR_W'(slot_m2);
      default: rd_addr = base_addr + ADDR_W'(slot_cur);
    endcase
  end
  assign mem_we = (state_q == S_RD_P1);

  // Read and write the window memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[base_addr + ADDR_W'(slot_cur)] <= price_q;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Feed the shared multiplier; hold the last product while the result waits
  always_comb begin
    case (state_q) inside
      S_MUL1: begin
        mul_a = mul_p[SUM_W-1:0];
        mul_b = PCT_SCALE;
      end
      S_MUL2: begin
        mul_a = sum_q;
        mul_b = low_pct_q;
      end
      S_MUL3, S_DONE: begin
        mul_a = sum_q;
        mul_b = high_pct_q;
      end
      default: begin
        mul_a = SUM_W'(price_q);
        mul_b = PCT_W'(cnt_q);
      end
    endcase
  end

  tsoe_mul #(
    .A_W(SUM_W),
    .B_W(PCT_W)
  ) u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Assemble the result from the collected test outcomes
  always_comb begin
    logic             thr, dev, mom, buy, sell;
    logic [PRICE_W:0] up;
    thr  = vld_q && ((price_q < low_limit_q) || (price_q > high_limit_q));
    dev  = vld_q && (32'(cnt_q) >= DEV_MIN_COUNT) && (dev_lo_q || (lhs_q > mul_p));
    mom  = vld_q && mom_q;
    buy  = thr || mom || (dev && below_q);
    sell = dev && !below_q;
    up   = {1'b0, price_q} + (PRICE_W + 1)'(offset_q);
    result.order_valid      = buy || sell;
    result.is_buy           = buy;
    result.order_instrument = inst_q;
    result.threshold_hit    = thr;
    result.deviation_hit    = dev;
    result.momentum_hit     = mom;
    if (buy) begin
      result.order_price = up[PRICE_W] ? PRICE_MAX : up[PRICE_W-1:0];
    end else if (sell) begin
      result.order_price = (price_q >= PRICE_W'(offset_q)) ? price_q - PRICE_W'(offset_q) : '0;
    end else begin
      result.order_price = '0;
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Sequence one request through reads, multiplies and result; out-of-range requests go straight to result
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (32'(in_data_i.inst_id) < NUM_INSTRUMENTS) ? S_RD_EV : S_DONE;
        end
      end
      S_RD_EV: state_d = S_RD_P1;
      S_RD_P1: state_d = S_RD_P2;
      S_RD_P2: state_d = S_MUL0;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_MUL3;
      S_MUL3:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LOW_LIMIT_RST;
      high_limit_q <= HIGH_LIMIT_RST;
      low_pct_q    <= LOW_PCT_RST;
      high_pct_q   <= HIGH_PCT_RST;
      offset_q     <= OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOW_LIMIT:  low_limit_q  <= cfg_data_i[PRICE_W-1:0];
        CFG_HIGH_LIMIT: high_limit_q <= cfg_data_i[PRICE_W-1:0];
        CFG_LOW_PCT:    low_pct_q    <= cfg_data_i[PCT_W-1:0];
        CFG_HIGH_PCT:   high_pct_q   <= cfg_data_i[PCT_W-1:0];
        CFG_OFFSET:     offset_q     <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the per-instrument sum, fill count and write slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NI_EFF; i++) begin
        sum_arr_q[i]  <= '0;
        cnt_arr_q[i]  <= '0;
        slot_arr_q[i] <= '0;
      end
    end else if (state_q == S_RD_P2) begin
      sum_arr_q[idx]  <= sum_new;
      cnt_arr_q[idx]  <= full ? cnt_cur : cnt_cur + 1'b1;
      slot_arr_q[idx] <= slot_nxt;
    end
  end

  // Hold the tick context and intermediate results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_acc) begin
      vld_q <= (32'(in_data_i.inst_id) < NUM_INSTRUMENTS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      inst_q  <= in_data_i.inst_id;
      price_q <= in_data_i.price;
    end
    unique case (state_q)
      S_RD_P1: ev_q <= rd_q;
      S_RD_P2: begin
        p1_q  <= rd_q;
        sum_q <= sum_new;
        cnt_q <= full ? cnt_cur : cnt_cur + 1'b1;
      end
      S_MUL0: begin
        mom_q <= (32'(cnt_q) >= MOM_MIN_COUNT) && (p1_q > rd_q) && (price_q > p1_q);
      end
      S_MUL1:  below_q  <= (mul_p < PROD_W'(sum_q));
      S_MUL2:  lhs_q    <= mul_p;
      S_MUL3:  dev_lo_q <= (lhs_q < mul_p);
      default: ;
    endcase
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_RST(a_acc_busy, in_acc |=> in_stall_o, "accepted request did not make the block busy")
  `ASSERT_RST(a_load_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE), "result shown outside the done step")
  `ASSERT_RST(a_cnt_range, (state_q == S_MUL0 && vld_q) |-> (cnt_q != '0 && 32'(cnt_q) <= WINDOW), "fill count out of range")
  `ASSERT_CLK(a_buy_is_order, out_valid_o |-> (!out_data_o.is_buy || out_data_o.order_valid), "buy side without an order")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tsoe_pkg::*;

  localparam int unsigned WINDOW    = 10;
  localparam int unsigned NUM_INST  = 16;
  localparam int unsigned LATENCY   = 9;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  tick_t            in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  order_t           out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 85;
  int unsigned mismatch_count = 0;

  // Orders still owed by the block, newest first
  order_t expected_orders[$];

  // Shadow configuration
  logic [PRICE_W-1:0] low_limit  = LOW_LIMIT_RST;
  logic [PRICE_W-1:0] high_limit = HIGH_LIMIT_RST;
  logic [PCT_W-1:0]   low_pct    = LOW_PCT_RST;
  logic [PCT_W-1:0]   high_pct   = HIGH_PCT_RST;
  logic [PCT_W-1:0]   offset     = OFFSET_RST;

  // Shadow per-instrument price windows
  logic [PRICE_W-1:0] win_price [NUM_INST][WINDOW];
  logic [27:0]        win_sum   [NUM_INST] = '{default: '0};
  int unsigned        win_fill  [NUM_INST] = '{default: 0};
  int unsigned        win_slot  [NUM_INST] = '{default: 0};

  tick_signal_order_engine_core #(
    .WINDOW          (WINDOW),
    .NUM_INSTRUMENTS (NUM_INST)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Push the tick into its window, then run the three tests
  function automatic order_t predict_order(tick_t t);
    order_t             o;
    int unsigned        id;
    int unsigned        slot;
    int unsigned        cnt;
    longint unsigned    p;
    longint unsigned    sum;
    longint unsigned    scaled;
    logic [PRICE_W-1:0] prev1;
    logic [PRICE_W-1:0] prev2;
    logic [PRICE_W:0]   raised;
    logic               thr;
    logic               dev;
    logic               mom;
    logic               buy;
    logic               sell;
    o    = '0;
    thr  = 1'b0;
    dev  = 1'b0;
    mom  = 1'b0;
    buy  = 1'b0;
    sell = 1'b0;
    id   = 32'(t.inst_id);
    p    = 64'(t.price);
    if (id < NUM_INST) begin
      slot = win_slot[id];
      if (win_fill[id] >= WINDOW) begin
        win_sum[id] = win_sum[id] - win_price[id][slot];
      end else begin
        win_fill[id]++;
      end
      win_price[id][slot] = t.price;
      win_sum[id]  = win_sum[id] + t.price;
      win_slot[id] = (slot + 1) % WINDOW;
      cnt = win_fill[id];
      sum = 64'(win_sum[id]);

      thr = (t.price < low_limit) || (t.price > high_limit);

      if (cnt >= DEV_MIN_COUNT) begin
        scaled = p * cnt * PCT_SCALE;
        dev = (scaled < sum * low_pct) || (scaled > sum * high_pct);
      end

      if (cnt >= MOM_MIN_COUNT) begin
        prev1 = win_price[id][(slot + WINDOW - 1) % WINDOW];
        prev2 = win_price[id][(slot + WINDOW - 2) % WINDOW];
        mom = (prev1 > prev2) && (t.price > prev1);
      end

      buy = thr || mom;
      if (dev) begin
        if (p * cnt < sum) buy = 1'b1;
        else sell = 1'b1;
      end

      // Saturate the order price at both ends
      if (buy) begin
        raised = {1'b0, t.price} + offset;
        o.order_price = (raised > PRICE_MAX) ? PRICE_MAX : raised[PRICE_W-1:0];
      end else if (sell) begin
        o.order_price = (t.price >= offset) ? t.price - offset : '0;
      end
    end
    o.order_valid      = buy || sell;
    o.is_buy           = buy;
    o.order_instrument = t.inst_id;
    o.threshold_hit    = thr;
    o.deviation_hit    = dev;
    o.momentum_hit     = mom;
    return o;
  endfunction

  function automatic void check_field(string name, logic [PRICE_W-1:0] want,
                                      logic [PRICE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Randomly stall the result channel
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare each accepted order with the oldest prediction
  always @(posedge clk_i) begin : check_orders
    order_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_orders.size() == 0) begin
        $error("order for instrument %0d with no request pending",
               out_data.order_instrument);
        mismatch_count++;
      end else begin
        want = expected_orders.pop_back();
        check_field("order_valid", want.order_valid, out_data.order_valid);
        check_field("is_buy", want.is_buy, out_data.is_buy);
        check_field("order_price", want.order_price, out_data.order_price);
        check_field("order_instrument", want.order_instrument,
                    out_data.order_instrument);
        check_field("threshold_hit", want.threshold_hit, out_data.threshold_hit);
        check_field("deviation_hit", want.deviation_hit, out_data.deviation_hit);
        check_field("momentum_hit", want.momentum_hit, out_data.momentum_hit);
      end
    end
  end

  // Send one tick request, idling first at random
  task automatic send_tick(input logic [INST_W-1:0] id, input logic [PRICE_W-1:0] price);
    tick_t t;
    t.inst_id = id;
    t.price   = price;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    expected_orders.push_front(predict_order(t));
  endtask

  // Drop valid and drain every owed order
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (expected_orders.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
  endtask

  // Write all five registers, then one unused index that must be ignored
  task automatic apply_config(input logic [CFG_DATA_W-1:0] lo, hi, lp, hp, off);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] data [6];
    idx  = '{CFG_LOW_LIMIT, CFG_HIGH_LIMIT, CFG_LOW_PCT, CFG_HIGH_PCT, CFG_OFFSET,
             CFG_OFFSET + CFG_IDX_W'($urandom_range(1, 3))};
    data = '{lo, hi, lp, hp, off, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= data[i];
      @(posedge clk_i);
      case (idx[i])
        CFG_LOW_LIMIT:  low_limit  = data[i];
        CFG_HIGH_LIMIT: high_limit = data[i];
        CFG_LOW_PCT:    low_pct    = data[i][PCT_W-1:0];
        CFG_HIGH_PCT:   high_pct   = data[i][PCT_W-1:0];
        CFG_OFFSET:     offset     = data[i][PCT_W-1:0];
        default: ;
      endcase
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Threshold, momentum, deviation both sides, no order, saturation at the top
  task automatic test_directed_signals();
    send_idle_pct = 12;
    recv_idle_pct = 85;
    send_tick(4'd0, 24'd0);
    send_tick(4'd0, 24'd15000);
    send_tick(4'd0, 24'd16000);
    send_tick(4'd0, 24'd17000);
    send_tick(4'd0, 24'd15000);
    send_tick(4'd0, 24'd15000);
    send_tick(4'd0, PRICE_MAX);
    // Sell: price far above the window mean, inside the band
    for (int i = 0; i < 5; i++) send_tick(4'd1, 24'd11000);
    send_tick(4'd1, 24'd19000);
    // No test fires
    send_tick(4'd2, 24'd15000);
    // Momentum alone
    send_tick(4'd3, 24'd12000);
    send_tick(4'd3, 24'd13000);
    send_tick(4'd3, 24'd14000);
    // Deviation buy below the mean
    for (int i = 0; i < 5; i++) send_tick(4'd4, 24'd18000);
    send_tick(4'd4, 24'd11000);
    send_tick(4'd15, PRICE_MAX);
  endtask

  // Register extremes, sell saturating at zero, then back to reset values
  task automatic test_config_extremes();
    wait_idle();
    apply_config('0, PRICE_MAX, '0, '0, 24'd255);
    for (int i = 0; i < 5; i++) send_tick(4'd6, 24'd0);
    send_tick(4'd6, 24'd5);
    send_tick(4'd6, PRICE_MAX);
    wait_idle();
    apply_config(PRICE_MAX, '0, 24'd255, 24'd255, '0);
    for (int i = 0; i < 6; i++) send_tick(4'd7, 24'd100);
    send_tick(4'd7, PRICE_MAX);
    send_tick(4'd7, 24'd0);
    wait_idle();
    apply_config(LOW_LIMIT_RST, HIGH_LIMIT_RST, CFG_DATA_W'(LOW_PCT_RST),
                 CFG_DATA_W'(HIGH_PCT_RST), CFG_DATA_W'(OFFSET_RST));
  endtask

  // Mostly price walks, trends and spikes per instrument, some prices near the limits and raw noise
  task automatic test_random_ticks(input int unsigned send_pct, recv_pct, count,
                                   input bit wide);
    int                 level [NUM_INST];
    int unsigned        r;
    logic [INST_W-1:0]  id;
    logic [PRICE_W-1:0] price;
    wait_idle();
    if (wide) begin
      apply_config(CFG_DATA_W'($urandom_range(0, 30000)),
                   CFG_DATA_W'($urandom_range(0, 40000)), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    end else begin
      apply_config(CFG_DATA_W'($urandom_range(9000, 13000)),
                   CFG_DATA_W'($urandom_range(17000, 23000)),
                   CFG_DATA_W'($urandom_range(50, 95)),
                   CFG_DATA_W'($urandom_range(105, 160)),
                   CFG_DATA_W'($urandom_range(0, 255)));
    end
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < NUM_INST; k++) level[k] = $urandom_range(9000, 21000);
    for (int unsigned n = 0; n < count; n++) begin
      id = INST_W'($urandom_range(0, NUM_INST - 1));
      r  = $urandom_range(0, 99);
      if (r < 55) begin
        level[id] = level[id] + int'($urandom_range(0, 600)) - 300;
      end else if (r < 70) begin
        level[id] = level[id] + int'($urandom_range(1, 300));
      end
      if (level[id] < 500) level[id] = 500;
      if (level[id] > 40000) level[id] = 40000;
      price = PRICE_W'(level[id]);
      if (r >= 70 && r < 85) begin
        price = PRICE_W'(level[id] * int'($urandom_range(30, 170)) / 100);
      end else if (r >= 85 && r < 92) begin
        price = ($urandom_range(0, 1) ? low_limit : high_limit)
                + PRICE_W'($urandom_range(0, 2)) - PRICE_W'(1);
      end else if (r >= 92) begin
        case ($urandom_range(0, 3))
          0:       price = '0;
          1:       price = PRICE_MAX;
          default: price = PRICE_W'($urandom);
        endcase
      end
      send_tick(id, price);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_signals();
    test_config_extremes();
    test_random_ticks(12, 85, 400, 1'b0);
    test_random_ticks(85, 12, 400, 1'b1);
    test_random_ticks(0, 0, 400, 1'b0);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tick_signal_order_engine_core test passed");
    end else begin
      $display("tick_signal_order_engine_core test failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("tick_signal_order_engine_core test failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tsoe_pkg.sv
hw/rtl/tsoe_mul.sv
hw/rtl/tick_signal_order_engine_core.sv
tb/testbench.sv
